>>> src/mesi_set_assoc_cache_lru_assert.svh
// Assertion macros used by the cache top level.
// Expects signals named clock and reset in the module that uses them.
`ifndef MESI_SET_ASSOC_CACHE_LRU_ASSERT_SVH
`define MESI_SET_ASSOC_CACHE_LRU_ASSERT_SVH

`ifndef SYNTHESIS

// Check that pre implies post in the same cycle.
`define MC_ASSERT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check that pre implies post in the next cycle.
`define MC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define MC_ASSERT(lbl, pre, post, msg)

`define MC_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

>>> src/mcache_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the set-associative MESI cache.
// No dependencies; imported by mcache_lookup, the top level and the testbench.
package mcache_pkg;

   localparam int PERMIT_W = 2;

   localparam logic [PERMIT_W-1:0] PERMIT_INVALID   = 2'd0;
   localparam logic [PERMIT_W-1:0] PERMIT_SHARED    = 2'd1;
   localparam logic [PERMIT_W-1:0] PERMIT_EXCLUSIVE = 2'd2;
   localparam logic [PERMIT_W-1:0] PERMIT_MODIFIED  = 2'd3;

   localparam logic [1:0] ACT_LOAD       = 2'd0;
   localparam logic [1:0] ACT_STORE      = 2'd1;
   localparam logic [1:0] ACT_FILL       = 2'd2;
   localparam logic [1:0] ACT_SET_PERMIT = 2'd3;

   typedef struct packed {
      logic [1:0]          action;
      logic [31:0]         address;
      logic [7:0]          bus_tag;
      logic signed [31:0]  word_value;
      logic                retried;
      logic [PERMIT_W-1:0] new_permit;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic                retry;
      logic signed [31:0]  read_word;
      logic                request_valid;
      logic [31:0]         request_address;
      logic [7:0]          request_tag;
      logic [PERMIT_W-1:0] request_permit;
      logic [31:0]         full_hit_count;
      logic [31:0]         partial_hit_count;
      logic [31:0]         miss_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] full_cnt;
      logic [31:0] part_cnt;
      logic [31:0] misses;
   } cnt_type;

endpackage

>>> src/mcache_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same row returns the old contents.
module mcache_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/mcache_lookup.sv
`timescale 1ns / 1ps
// Tag compare, MESI decision, LRU update and counter update for one word.
// Uses mcache_pkg; purely combinational, sits between the set read and the result register.
module mcache_lookup
   import mcache_pkg::*;
#(
   parameter int LOG_WAYS = 2,
   parameter int LOG_SETS = 6,
   parameter int LOG_LINE_WORDS = 2,
   localparam int NWAYS = 1 << LOG_WAYS,
   localparam int WAYW = (LOG_WAYS > 0) ? LOG_WAYS : 1,
   localparam int TAGW = 32 - LOG_SETS - LOG_LINE_WORDS,
   localparam int ENTW = TAGW + PERMIT_W + WAYW
) (
   input  req_type                        s1_req,
   input  logic [NWAYS-1:0][ENTW-1:0]     tag_row,
   input  logic [NWAYS-1:0][31:0]         data_row,
   input  cnt_type                        cnt,
   output logic [NWAYS-1:0][ENTW-1:0]     tag_row_new,
   output logic [NWAYS-1:0][31:0]         data_row_new,
   output cnt_type                        cnt_new,
   output rsp_type                        rsp
);

   logic [TAGW-1:0]                 tag;
   logic [NWAYS-1:0][TAGW-1:0]      way_tag;
   logic [NWAYS-1:0][PERMIT_W-1:0]  way_perm;
   logic [NWAYS-1:0][WAYW-1:0]      way_rank;
   logic [NWAYS-1:0][PERMIT_W-1:0]  perm_new;
   logic [NWAYS-1:0][WAYW-1:0]      rank_new;
   logic                            match_found;
   logic [WAYW-1:0]                 match_way;
   logic [WAYW-1:0]                 lru_way;
   logic [WAYW-1:0]                 victim;
   logic [WAYW-1:0]                 cur_rank;
   logic [PERMIT_W-1:0]             m_perm;
   logic is_load, is_store, is_fill, is_setp;
   logic load_hit, store_hit, store_part, miss_ev, need_retry, send_req, touch;

   function automatic logic [31:0] sat_inc(logic [31:0] c, logic en);
      return (en && (c != 32'hFFFF_FFFF)) ? c + 32'd1 : c;
   endfunction

   assign tag = TAGW'(s1_req.address >> (LOG_SETS + LOG_LINE_WORDS));

   always_comb begin
      for (int w = 0; w < NWAYS; w++) begin
         way_tag[w]  = tag_row[w][ENTW-1 -: TAGW];
         way_perm[w] = tag_row[w][WAYW +: PERMIT_W];
         way_rank[w] = tag_row[w][WAYW-1:0];
      end
   end

   // lowest matching way, whatever its permission; lowest way at rank zero
   always_comb begin
      match_found = 1'b0;
      match_way   = '0;
      lru_way     = '0;
      for (int w = NWAYS - 1; w >= 0; w--) begin
         if (way_tag[w] == tag) begin
            match_found = 1'b1;
            match_way   = WAYW'(w);
         end
         if (way_rank[w] == '0) begin
            lru_way = WAYW'(w);
         end
      end
   end

   always_comb begin
      is_load  = 1'b0;
      is_store = 1'b0;
      is_fill  = 1'b0;
      is_setp  = 1'b0;
      unique case (s1_req.action)
         ACT_LOAD:       is_load  = 1'b1;
         ACT_STORE:      is_store = 1'b1;
         ACT_FILL:       is_fill  = 1'b1;
         ACT_SET_PERMIT: is_setp  = 1'b1;
         default:        is_load  = 1'b0;
      endcase
   end

   assign m_perm     = match_found ? way_perm[match_way] : PERMIT_INVALID;
   assign load_hit   = is_load && (m_perm != PERMIT_INVALID);
   assign store_hit  = is_store && ((m_perm == PERMIT_EXCLUSIVE) ||
                                    (m_perm == PERMIT_MODIFIED));
   assign store_part = is_store && (m_perm == PERMIT_SHARED);
   assign need_retry = (is_load && !load_hit) || (is_store && !store_hit);
   assign miss_ev    = need_retry && !store_part;
   assign send_req   = need_retry && !s1_req.retried;
   assign touch      = load_hit || store_hit || is_fill;
   assign victim     = (is_fill && !match_found) ? lru_way : match_way;
   assign cur_rank   = way_rank[victim];

   // make the touched way most recent, close the gap above its old rank
   always_comb begin
      for (int w = 0; w < NWAYS; w++) begin
         perm_new[w] = way_perm[w];
         rank_new[w] = way_rank[w];
         if (touch) begin
            if (WAYW'(w) == victim) begin
               rank_new[w] = WAYW'(NWAYS - 1);
            end else if (way_rank[w] > cur_rank) begin
               rank_new[w] = way_rank[w] - WAYW'(1);
            end
         end
      end
      if (store_hit) begin
         perm_new[match_way] = PERMIT_MODIFIED;
      end
      if (is_fill) begin
         perm_new[victim] = s1_req.new_permit;
      end
      if (is_setp && match_found) begin
         perm_new[match_way] = s1_req.new_permit;
      end
      for (int w = 0; w < NWAYS; w++) begin
         tag_row_new[w] = {(is_fill && (WAYW'(w) == victim)) ? tag : way_tag[w],
                           perm_new[w], rank_new[w]};
      end
   end

   always_comb begin
      data_row_new = data_row;
      if (store_hit || is_fill) begin
         data_row_new[victim] = s1_req.word_value;
      end
   end

   always_comb begin
      cnt_new.full_cnt = sat_inc(cnt.full_cnt, (load_hit || store_hit) && !s1_req.retried);
      cnt_new.part_cnt = sat_inc(cnt.part_cnt, store_part && !s1_req.retried);
      cnt_new.misses   = sat_inc(cnt.misses, miss_ev && !s1_req.retried);
   end

   always_comb begin
      rsp.hit               = load_hit || store_hit;
      rsp.retry             = need_retry;
      rsp.read_word         = load_hit ? $signed(data_row[match_way]) : 32'sd0;
      rsp.request_valid     = send_req;
      rsp.request_address   = send_req ? s1_req.address : 32'd0;
      rsp.request_tag       = send_req ? s1_req.bus_tag : 8'd0;
      rsp.request_permit    = !send_req ? PERMIT_INVALID :
                              (is_load ? PERMIT_SHARED : PERMIT_MODIFIED);
      rsp.full_hit_count    = cnt_new.full_cnt;
      rsp.partial_hit_count = cnt_new.part_cnt;
      rsp.miss_count        = cnt_new.misses;
   end

endmodule

>>> src/mesi_set_assoc_cache_lru.sv
`timescale 1ns / 1ps
// Top level of the blocking set-associative MESI cache with true-LRU replacement.
// Depends on mcache_pkg, mcache_ram, mcache_lookup and the assertion macro header.
//
// Usage:
//   Request words enter on req_valid/req_stall/req_data (load, store, fill,
//   set-permission); each yields exactly one result word on
//   rsp_valid/rsp_stall/rsp_data with hit, retry, read word, an optional
//   outgoing read request and the three saturating counters after the access.
//   The tag/permission/LRU RAM and the data RAM are read at the accepting
//   edge into the lookup stage, which compares all ways and decides; when the
//   stage advances it writes the set back while the result lands in the output
//   register.
//   Throughput: one word per cycle while rsp_stall is low, set by the single read
//   and single write port of each RAM; a write to the set the following word reads is forwarded.
//   Reset: a clearing pass writes every RAM row to its reset contents, one row
//   a cycle; req_stall stays high for the pass.
//   Stall: while rsp_stall holds a waiting result, the word in the lookup stage
//   holds, and the next word is accepted only once the output register frees.
`include "mesi_set_assoc_cache_lru_assert.svh"
module mesi_set_assoc_cache_lru
   import mcache_pkg::*;
#(
   parameter int LOG_WAYS = 2,
   parameter int LOG_SETS = 6,
   parameter int LOG_LINE_WORDS = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NWAYS = 1 << LOG_WAYS;
   localparam int WAYW = (LOG_WAYS > 0) ? LOG_WAYS : 1;
   localparam int SETW = (LOG_SETS > 0) ? LOG_SETS : 1;
   localparam int OFFW = (LOG_LINE_WORDS > 0) ? LOG_LINE_WORDS : 1;
   localparam int TAGW = 32 - LOG_SETS - LOG_LINE_WORDS;
   localparam int ENTW = TAGW + PERMIT_W + WAYW;
   localparam int ROWW = SETW + OFFW;
   localparam int SET_DEPTH = 1 << SETW;
   localparam int ROW_DEPTH = 1 << ROWW;

   // clearing pass
   logic            clr_active_ff, clr_active_in;
   logic [ROWW-1:0] clr_cnt_ff, clr_cnt_in;

   // lookup stage
   logic            s1_valid_ff, s1_valid_in;
   req_type         s1_req_ff, s1_req_in;
   logic [ROWW-1:0] s1_row_ff, s1_row_in;

   // last RAM write, for forwarding into the lookup stage
   logic                        fwd_valid_ff, fwd_valid_in;
   logic [ROWW-1:0]             fwd_row_ff, fwd_row_in;
   logic [NWAYS-1:0][ENTW-1:0]  fwd_tag_ff, fwd_tag_in;
   logic [NWAYS-1:0][31:0]      fwd_data_ff, fwd_data_in;

   // result and counters
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   cnt_type cnt_ff, cnt_in;

   logic                        req_accept, adv;
   logic [ROWW-1:0]             req_row;
   logic                        wr_en;
   logic [ROWW-1:0]             wr_row;
   logic [NWAYS-1:0][ENTW-1:0]  wr_tag, clr_tag_row, tag_rd, tag_cur, tag_new;
   logic [NWAYS-1:0][31:0]      wr_data, data_rd, data_cur, data_new;
   cnt_type                     cnt_new;
   rsp_type                     rsp_new;

   function automatic logic [ROWW-1:0] row_of(logic [31:0] a);
      logic [31:0]     sh;
      logic [SETW-1:0] s;
      logic [OFFW-1:0] o;
      sh = a >> LOG_LINE_WORDS;
      s  = (LOG_SETS > 0) ? sh[SETW-1:0] : '0;
      o  = (LOG_LINE_WORDS > 0) ? a[OFFW-1:0] : '0;
      return {s, o};
   endfunction

   // handshake: advance the lookup stage when the output register is free
   assign adv        = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clr_active_ff || (s1_valid_ff && !adv);
   assign req_accept = req_valid && !req_stall;
   assign req_row    = row_of(req_data.address);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // reset contents of one set: tag zero, invalid, rank equal to way
   always_comb begin
      for (int w = 0; w < NWAYS; w++) begin
         clr_tag_row[w] = {{TAGW{1'b0}}, PERMIT_INVALID, WAYW'(w)};
      end
   end

   // one write port per RAM: clearing pass first, then the lookup stage
   always_comb begin
      if (clr_active_ff) begin
         wr_en   = 1'b1;
         wr_row  = clr_cnt_ff;
         wr_tag  = clr_tag_row;
         wr_data = '0;
      end else begin
         wr_en   = adv;
         wr_row  = s1_row_ff;
         wr_tag  = tag_new;
         wr_data = data_new;
      end
   end

   mcache_ram #(
      .WIDTH(NWAYS * ENTW),
      .DEPTH(SET_DEPTH)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_row[ROWW-1:OFFW]),
      .wr_data(wr_tag),
      .rd_en  (req_accept),
      .rd_addr(req_row[ROWW-1:OFFW]),
      .rd_data(tag_rd)
   );

   mcache_ram #(
      .WIDTH(NWAYS * 32),
      .DEPTH(ROW_DEPTH)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_row),
      .wr_data(wr_data),
      .rd_en  (req_accept),
      .rd_addr(req_row),
      .rd_data(data_rd)
   );

   // take the latest write of the same set or row over the stale RAM read
   assign tag_cur  = (fwd_valid_ff && (fwd_row_ff[ROWW-1:OFFW] == s1_row_ff[ROWW-1:OFFW]))
                     ? fwd_tag_ff : tag_rd;
   assign data_cur = (fwd_valid_ff && (fwd_row_ff == s1_row_ff)) ? fwd_data_ff : data_rd;

   mcache_lookup #(
      .LOG_WAYS      (LOG_WAYS),
      .LOG_SETS      (LOG_SETS),
      .LOG_LINE_WORDS(LOG_LINE_WORDS)
   ) u_lookup (
      .s1_req      (s1_req_ff),
      .tag_row     (tag_cur),
      .data_row    (data_cur),
      .cnt         (cnt_ff),
      .tag_row_new (tag_new),
      .data_row_new(data_new),
      .cnt_new     (cnt_new),
      .rsp         (rsp_new)
   );

   always_comb begin
      // walk every row once, then open the request channel
      clr_active_in = clr_active_ff && (clr_cnt_ff != '1);
      clr_cnt_in    = clr_active_ff ? clr_cnt_ff + ROWW'(1) : clr_cnt_ff;

      s1_valid_in = req_accept || (s1_valid_ff && !adv);
      s1_req_in   = req_accept ? req_data : s1_req_ff;
      s1_row_in   = req_accept ? req_row : s1_row_ff;

      fwd_valid_in = fwd_valid_ff || wr_en;
      fwd_row_in   = wr_en ? wr_row : fwd_row_ff;
      fwd_tag_in   = wr_en ? wr_tag : fwd_tag_ff;
      fwd_data_in  = wr_en ? wr_data : fwd_data_ff;

      // hold a stalled result, drop it once taken
      rsp_valid_in = adv || (rsp_valid_ff && rsp_stall);
      rsp_in       = adv ? rsp_new : rsp_ff;
      cnt_in       = adv ? cnt_new : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      s1_row_ff   <= s1_row_in;
      fwd_row_ff  <= fwd_row_in;
      fwd_tag_ff  <= fwd_tag_in;
      fwd_data_ff <= fwd_data_in;
      rsp_ff      <= rsp_in;
   end

   `MC_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !adv, s1_valid_ff && $stable(s1_row_ff), "word lost")
   `MC_ASSERT(a_hit_xor_retry, rsp_valid_ff, !(rsp_ff.hit && rsp_ff.retry), "hit and retry")
   `MC_ASSERT(a_req_retry, rsp_valid_ff && rsp_ff.request_valid, rsp_ff.retry, "bad request")
   `MC_ASSERT(a_miss_up, !$past(reset), cnt_ff.misses >= $past(cnt_ff.misses), "miss count fell")
   `MC_ASSERT(a_hit_up, !$past(reset), cnt_ff.full_cnt >= $past(cnt_ff.full_cnt), "hit count fell")

endmodule

>>> tb/tb_mesi_set_assoc_cache_lru.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative MESI cache with true-LRU replacement.
// Depends on mcache_pkg and mesi_set_assoc_cache_lru; holds its own cache predictor.
module tb_mesi_set_assoc_cache_lru;
   import mcache_pkg::*;

   localparam int LOG_WAYS       = 2;
   localparam int LOG_SETS       = 6;
   localparam int LOG_WORDS      = 2;
   localparam int NUM_WAYS       = 1 << LOG_WAYS;
   localparam int NUM_LINES      = (1 << LOG_SETS) * NUM_WAYS;
   localparam int NUM_WORDS      = 1 << LOG_WORDS;
   localparam int TAG_W          = 32 - LOG_SETS - LOG_WORDS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_LEN   = 64;
   localparam int RANDOM_ITEMS   = 500;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   mesi_set_assoc_cache_lru #(
      .LOG_WAYS(LOG_WAYS),
      .LOG_SETS(LOG_SETS),
      .LOG_LINE_WORDS(LOG_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Shadow copy of the cache: tags, permissions, LRU ranks, data and counters.
   logic [TAG_W-1:0]    tag_mem    [NUM_LINES];
   logic [PERMIT_W-1:0] permit_mem [NUM_LINES];
   logic [LOG_WAYS-1:0] rank_mem   [NUM_LINES];
   logic [31:0]         word_mem   [NUM_LINES*NUM_WORDS];
   logic [31:0]         full_total;
   logic [31:0]         part_total;
   logic [31:0]         misses;

   // Results owed by the cache, oldest first.
   rsp_type pending_rsp[$];

   // Address pools that keep random traffic inside a few sets so lines collide.
   logic [TAG_W-1:0]    tag_pool [6];
   logic [LOG_SETS-1:0] set_pool [3];

   int  errors;
   int  words_sent;
   int  words_checked;
   int  hits_seen;
   int  retries_seen;
   int  requests_seen;
   int  idle_cycles;
   int  hold_cycles;
   bit  quiet;
   rsp_type want;

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] sat_inc(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   // Lowest way whose tag matches, whatever its permission; -1 if none.
   function automatic int find_way(logic [LOG_SETS-1:0] s, logic [TAG_W-1:0] t);
      int found;
      found = -1;
      for (int w = NUM_WAYS - 1; w >= 0; w--)
         if (tag_mem[{s, w[LOG_WAYS-1:0]}] == t) found = w;
      return found;
   endfunction

   // Promote one way to most recent; close the gap it leaves in the ranks.
   function automatic void make_recent(logic [LOG_SETS-1:0] s, logic [LOG_WAYS-1:0] w);
      logic [LOG_WAYS-1:0] cur;
      cur = rank_mem[{s, w}];
      for (int i = 0; i < NUM_WAYS; i++)
         if (rank_mem[{s, i[LOG_WAYS-1:0]}] > cur)
            rank_mem[{s, i[LOG_WAYS-1:0]}] = rank_mem[{s, i[LOG_WAYS-1:0]}] - 1'b1;
      rank_mem[{s, w}] = LOG_WAYS'(NUM_WAYS - 1);
   endfunction

   function automatic void clear_cache_model();
      for (int i = 0; i < NUM_LINES; i++) begin
         tag_mem[i]    = '0;
         permit_mem[i] = PERMIT_INVALID;
         rank_mem[i]   = i[LOG_WAYS-1:0];
      end
      for (int i = 0; i < NUM_LINES * NUM_WORDS; i++) word_mem[i] = '0;
      full_total = '0;
      part_total = '0;
      misses     = '0;
   endfunction

   // Apply one access to the shadow cache and return the result it must produce.
   function automatic rsp_type cache_predict(req_type r);
      rsp_type                      e;
      logic [LOG_SETS-1:0]          set_i;
      logic [TAG_W-1:0]             tag_i;
      logic [LOG_WORDS-1:0]         off_i;
      logic [LOG_SETS+LOG_WAYS-1:0] line;
      logic [PERMIT_W-1:0]          p;
      int                           way;
      bit                           found;
      e     = '0;
      set_i = r.address[LOG_WORDS +: LOG_SETS];
      tag_i = r.address[31 -: TAG_W];
      off_i = r.address[LOG_WORDS-1:0];
      way   = find_way(set_i, tag_i);
      line  = {set_i, way[LOG_WAYS-1:0]};
      case (r.action)
         ACT_LOAD: begin
            if (way >= 0 && permit_mem[line] != PERMIT_INVALID) begin
               if (!r.retried) full_total = sat_inc(full_total);
               e.hit       = 1'b1;
               e.read_word = word_mem[{line, off_i}];
               make_recent(set_i, way[LOG_WAYS-1:0]);
            end else begin
               if (!r.retried) begin
                  misses           = sat_inc(misses);
                  e.request_valid  = 1'b1;
                  e.request_permit = PERMIT_SHARED;
               end
               e.retry = 1'b1;
            end
         end
         ACT_STORE: begin
            p = PERMIT_INVALID;
            if (way >= 0) p = permit_mem[line];
            if (p >= PERMIT_EXCLUSIVE) begin
               if (!r.retried) full_total = sat_inc(full_total);
               permit_mem[line] = PERMIT_MODIFIED;
               make_recent(set_i, way[LOG_WAYS-1:0]);
               word_mem[{line, off_i}] = r.word_value;
               e.hit = 1'b1;
            end else begin
               if (!r.retried) begin
                  if (p == PERMIT_SHARED) part_total = sat_inc(part_total);
                  else misses = sat_inc(misses);
                  e.request_valid  = 1'b1;
                  e.request_permit = PERMIT_MODIFIED;
               end
               e.retry = 1'b1;
            end
         end
         ACT_FILL: begin
            // No tag match: take the least recent way, way 0 if ranks are broken.
            if (way < 0) begin
               way   = 0;
               found = 1'b0;
               for (int w = 0; w < NUM_WAYS; w++)
                  if (!found && rank_mem[{set_i, w[LOG_WAYS-1:0]}] == '0) begin
                     way   = w;
                     found = 1'b1;
                  end
               line = {set_i, way[LOG_WAYS-1:0]};
            end
            tag_mem[line]    = tag_i;
            permit_mem[line] = r.new_permit;
            make_recent(set_i, way[LOG_WAYS-1:0]);
            word_mem[{line, off_i}] = r.word_value;
         end
         default: begin
            if (way >= 0) permit_mem[line] = r.new_permit;
         end
      endcase
      if (e.request_valid) begin
         e.request_address = r.address;
         e.request_tag     = r.bus_tag;
      end
      e.full_hit_count    = full_total;
      e.partial_hit_count = part_total;
      e.miss_count        = misses;
      return e;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Idle length: a random pause, long one time in twenty, otherwise short.
   function automatic int pause_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Offer one word, hold it until accepted, then record what it must return.
   task automatic send_word(req_type r);
      int gap;
      gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pause_len();
      if (gap != 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(cache_predict(r));
      words_sent++;
   endtask

   task automatic send_fields(logic [1:0] act, logic [31:0] addr, logic [7:0] btag,
                              logic [31:0] wval, logic again, logic [PERMIT_W-1:0] perm);
      req_type r;
      r.action     = act;
      r.address    = addr;
      r.bus_tag    = btag;
      r.word_value = wval;
      r.retried    = again;
      r.new_permit = perm;
      send_word(r);
   endtask

   // Build an access inside the pooled tags and sets, random in all other fields.
   function automatic req_type pool_word(logic [1:0] act);
      req_type r;
      r.action     = act;
      r.address    = {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 2)],
                      LOG_WORDS'($urandom)};
      r.bus_tag    = 8'($urandom);
      r.word_value = $urandom;
      r.retried    = ($urandom_range(0, 6) == 0);
      r.new_permit = PERMIT_W'($urandom);
      return r;
   endfunction

   // Fresh cache: tag zero matches way 0 everywhere, but the line is invalid.
   task automatic test_reset_state();
      send_fields(ACT_LOAD, 32'h0000_0000, 8'h00, 32'h0, 1'b0, PERMIT_INVALID);
      send_fields(ACT_LOAD, 32'h0000_0000, 8'h5A, 32'h0, 1'b1, PERMIT_INVALID);
      send_fields(ACT_STORE, 32'h0000_0105, 8'hFF, 32'hFFFF_FFFF, 1'b0, PERMIT_INVALID);
      send_fields(ACT_SET_PERMIT, 32'h0000_1000, 8'h00, 32'h0, 1'b0, PERMIT_MODIFIED);
      send_fields(ACT_STORE, 32'h0000_0000, 8'h01, 32'h1, 1'b1, PERMIT_INVALID);
   endtask

   // Top of the address space: fill shared, partial hit, upgrade, store hits.
   task automatic test_fill_and_hit();
      send_fields(ACT_FILL, 32'hFFFF_FFFF, 8'h00, 32'h8000_0000, 1'b0, PERMIT_SHARED);
      send_fields(ACT_LOAD, 32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, PERMIT_INVALID);
      send_fields(ACT_STORE, 32'hFFFF_FFFF, 8'hA5, 32'h7FFF_FFFF, 1'b0, PERMIT_INVALID);
      send_fields(ACT_STORE, 32'hFFFF_FFFF, 8'hA5, 32'h7FFF_FFFF, 1'b1, PERMIT_INVALID);
      send_fields(ACT_FILL, 32'hFFFF_FFFE, 8'h00, 32'h7FFF_FFFF, 1'b0, PERMIT_EXCLUSIVE);
      send_fields(ACT_STORE, 32'hFFFF_FFFD, 8'h00, 32'h1234_5678, 1'b0, PERMIT_INVALID);
      send_fields(ACT_LOAD, 32'hFFFF_FFFD, 8'h00, 32'h0, 1'b0, PERMIT_INVALID);
      send_fields(ACT_LOAD, 32'hFFFF_FFFE, 8'h00, 32'h0, 1'b1, PERMIT_INVALID);
      send_fields(ACT_STORE, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 1'b0, PERMIT_INVALID);
   endtask

   // Fill all four ways of one set, touch the oldest, then force an eviction.
   task automatic test_lru_eviction();
      for (int t = 1; t <= NUM_WAYS; t++)
         send_fields(ACT_FILL, (t << 8) | 32'h14, 8'(t), t * 3, 1'b0, PERMIT_EXCLUSIVE);
      send_fields(ACT_LOAD, 32'h0000_0114, 8'h00, 32'h0, 1'b0, PERMIT_INVALID);
      send_fields(ACT_FILL, 32'h0000_0514, 8'h00, 32'h55, 1'b0, PERMIT_SHARED);
      send_fields(ACT_LOAD, 32'h0000_0214, 8'h22, 32'h0, 1'b0, PERMIT_INVALID);
   endtask

   // Drop a resident line to invalid, then raise it to modified and store.
   task automatic test_set_permit();
      send_fields(ACT_SET_PERMIT, 32'h0000_0114, 8'h00, 32'h0, 1'b0, PERMIT_INVALID);
      send_fields(ACT_LOAD, 32'h0000_0114, 8'h11, 32'h0, 1'b0, PERMIT_INVALID);
      send_fields(ACT_SET_PERMIT, 32'h0000_0114, 8'h00, 32'h0, 1'b0, PERMIT_MODIFIED);
      send_fields(ACT_STORE, 32'h0000_0115, 8'h00, 32'hDEAD_BEEF, 1'b0, PERMIT_INVALID);
   endtask

   // Hold the result channel off while words keep coming, so the input stalls.
   task automatic test_backpressure();
      quiet       = 1'b1;
      hold_cycles = HOLD_OFF_LEN;
      repeat (12) send_word(pool_word(2'($urandom_range(0, 3))));
      quiet = 1'b0;
   endtask

   // Mostly miss, fill, retry sequences in the pooled sets; the rest is noise.
   task automatic test_random(int n_items);
      req_type r;
      req_type f;
      int      sent;
      int      next_switch;
      int      kind;
      sent        = 0;
      next_switch = 0;
      while (sent < n_items) begin
         if (sent >= next_switch) begin
            quiet       = ($urandom_range(0, 3) == 0);
            next_switch = sent + $urandom_range(30, 80);
         end
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            r         = pool_word(2'($urandom_range(0, 1)));
            r.retried = 1'b0;
            send_word(r);
            f            = r;
            f.action     = ACT_FILL;
            f.word_value = $urandom;
            if ($urandom_range(0, 7) == 0) f.new_permit = PERMIT_W'($urandom);
            else if (r.action == ACT_LOAD) f.new_permit = PERMIT_W'($urandom_range(1, 3));
            else f.new_permit = PERMIT_W'($urandom_range(2, 3));
            send_word(f);
            r.retried    = 1'b1;
            r.word_value = $urandom;
            send_word(r);
            sent += 3;
         end else if (kind < 9) begin
            send_word(pool_word(2'($urandom_range(0, 3))));
            sent++;
         end else begin
            r.action     = 2'($urandom);
            r.address    = $urandom;
            r.bus_tag    = 8'($urandom);
            r.word_value = $urandom;
            r.retried    = 1'($urandom);
            r.new_permit = PERMIT_W'($urandom);
            send_word(r);
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
      errors++;
      if (errors <= 40)
         $display("[%0t] mismatch on %s: got %h, expected %h (result %0d)",
                  $time, what, got, exp_val, words_checked);
   endtask

   // Pop the oldest expectation for each accepted result; compare every field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_data.miss_count, '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", 32'(rsp_data.hit), 32'(want.hit));
            if (rsp_data.retry !== want.retry)
               report_mismatch("retry", 32'(rsp_data.retry), 32'(want.retry));
            if (rsp_data.read_word !== want.read_word)
               report_mismatch("read_word", rsp_data.read_word, want.read_word);
            if (rsp_data.request_valid !== want.request_valid)
               report_mismatch("request_valid", 32'(rsp_data.request_valid),
                               32'(want.request_valid));
            if (rsp_data.request_address !== want.request_address)
               report_mismatch("request_address", rsp_data.request_address,
                               want.request_address);
            if (rsp_data.request_tag !== want.request_tag)
               report_mismatch("request_tag", 32'(rsp_data.request_tag),
                               32'(want.request_tag));
            if (rsp_data.request_permit !== want.request_permit)
               report_mismatch("request_permit", 32'(rsp_data.request_permit),
                               32'(want.request_permit));
            if (rsp_data.full_hit_count !== want.full_hit_count)
               report_mismatch("full_hit_count", rsp_data.full_hit_count, want.full_hit_count);
            if (rsp_data.partial_hit_count !== want.partial_hit_count)
               report_mismatch("partial_hit_count", rsp_data.partial_hit_count,
                               want.partial_hit_count);
            if (rsp_data.miss_count !== want.miss_count)
               report_mismatch("miss_count", rsp_data.miss_count, want.miss_count);
            hits_seen     += int'(want.hit);
            retries_seen  += int'(want.retry);
            requests_seen += int'(want.request_valid);
         end
         words_checked++;
      end
   end

   // Drive the result stall: a requested hold-off first, else random pauses.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if (hold_cycles != 0) begin
            rsp_stall = 1'b1;
            while (hold_cycles != 0) begin
               @(negedge clock);
               hold_cycles--;
            end
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall = 1'b0;
            @(negedge clock);
         end else begin
            rsp_stall = 1'b1;
            repeat (pause_len()) @(negedge clock);
         end
      end
   end

   // Abort when neither channel moves a word for too long; covers the clearing pass.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      quiet         = 1'b0;
      hold_cycles   = 0;
      errors        = 0;
      words_sent    = 0;
      words_checked = 0;
      hits_seen     = 0;
      retries_seen  = 0;
      requests_seen = 0;
      idle_cycles   = 0;
      clear_cache_model();
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 6; i++) tag_pool[i] = TAG_W'($urandom);
      set_pool[0] = '0;
      set_pool[1] = '1;
      set_pool[2] = LOG_SETS'($urandom);

      // Hold reset, release it at a falling edge; the cache then clears its RAMs on its own.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_fill_and_hit();
      test_lru_eviction();
      test_set_permit();
      test_backpressure();
      test_random(RANDOM_ITEMS);

      @(negedge clock);
      req_valid = 1'b0;

      // Drain every owed result, then let the pipeline settle.
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Ran %0d accesses and checked %0d results: %0d hits, %0d retries, %0d requests.",
               words_sent, words_checked, hits_seen, retries_seen, requests_seen);
      $display("Final counters: %0d full hits, %0d partial hits, %0d misses; %0d mismatches.",
               full_total, part_total, misses, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/mcache_pkg.sv
src/mcache_ram.sv
src/mcache_lookup.sv
src/mesi_set_assoc_cache_lru.sv
tb/tb_mesi_set_assoc_cache_lru.sv
